// ----- rtl/sdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsa_pkg: shared types and constants of the SD card streaming sequencer
// Holds the register map, the register reset values, the block geometry and
// the structures that travel between the configuration, core and top level.
// ----------------------------------------------------------------------------
package sdsa_pkg;

    // Block geometry.
    localparam int PAIRS_PER_BLOCK = 256;   // byte pairs per data block, 1 to 256
    localparam int CMD8_TAIL_BYTES = 5;     // bytes skipped after CMD8, 0 to 8

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from byte address bits [3:2].
    localparam logic [1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [1:0] REG_POLL_LIMIT    = 2'd1;
    localparam logic [1:0] REG_WAKEUP_BYTES  = 2'd2;

    // Register reset values.
    localparam logic [31:0] START_ADDRESS_RST = 32'd0;
    localparam logic [7:0]  POLL_LIMIT_RST    = 8'd200;
    localparam logic [7:0]  WAKEUP_BYTES_RST  = 8'd20;

    // Status codes.
    localparam logic [1:0] ST_INIT   = 2'd0;
    localparam logic [1:0] ST_HALTED = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic [31:0] start_address;
        logic [7:0]  poll_limit;
        logic [7:0]  wakeup_bytes;
    } t_cfg;

    // One result of a byte exchange.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       card_select_n;
        logic       sample_valid;
        logic [7:0] sample;
        logic [1:0] status;
    } t_result;

endpackage

// ----- rtl/sdsa_if.sv -----
// ----------------------------------------------------------------------------
// sdsa_if: request and result channels of the SD card streaming sequencer
// Each channel carries valid, ready and its payload; a request or result
// moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface sdsa_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface sdsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       card_select_n;
    logic       sample_valid;
    logic [7:0] sample;
    logic [1:0] status;

    modport source (output valid, output tx_byte, output card_select_n,
                    output sample_valid, output sample, output status, input ready);
    modport sink   (input valid, input tx_byte, input card_select_n,
                    input sample_valid, input sample, input status, output ready);
endinterface

// ----- rtl/sd_spi_init_and_audio_stream.sv -----
// ----------------------------------------------------------------------------
// sd_spi_init_and_audio_stream: SD card SPI initialisation and audio streaming
// Top level: request register, sequencer core, result register and the
// configuration registers.
// ----------------------------------------------------------------------------
// A request accepted at a clock edge is held in the request register; its result is
// loaded into the result register once that register is empty or being emptied.
// Throughput: one request per cycle while the result channel does not stall; the
// sequencer state updates in the same cycle that the result register is loaded.
// Reset (synchronous, active low) empties both registers, restores the
// register defaults and puts the sequencer in the wake-up phase.
module sd_spi_init_and_audio_stream (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sdsa_in_if.sink                         i_in_chan,
    sdsa_out_if.source                      o_out_chan,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdsa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sdsa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sdsa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sdsa_pkg::*;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_rx;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    t_cfg       w_cfg;
    logic       w_advance;
    logic       w_step;

    // Pipeline control: the request register moves on when the result register
    // is empty or being emptied.
    assign w_advance       = !r_out_valid || o_out_chan.ready;
    assign w_step          = r_in_valid && w_advance;
    assign i_in_chan.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_chan.ready) begin
                r_in_valid <= i_in_chan.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_chan.valid && i_in_chan.ready) begin
            r_in_op <= i_in_chan.op;
            r_in_rx <= i_in_chan.rx_byte;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    sdsa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sdsa_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_op      (r_in_op),
        .i_rx_byte (r_in_rx),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    assign o_out_chan.valid         = r_out_valid;
    assign o_out_chan.tx_byte       = r_out.tx_byte;
    assign o_out_chan.card_select_n = r_out.card_select_n;
    assign o_out_chan.sample_valid  = r_out.sample_valid;
    assign o_out_chan.sample        = r_out.sample;
    assign o_out_chan.status        = r_out.status;

    // A held request always reaches the result register once it may advance.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("request lost between request and result registers");

    // Samples only come while streaming.
    a_sample_streaming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sample_valid |-> r_out.status == ST_STREAM)
        else $error("sample delivered outside streaming");

    // With the card deselected only idle bytes are sent.
    a_deselect_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.card_select_n |-> r_out.tx_byte == 8'hFF)
        else $error("data byte sent with card deselected");

    // The halted state always deselects the card.
    a_halt_deselect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_HALTED |-> r_out.card_select_n)
        else $error("card selected while halted");

endmodule

// ----- rtl/sdsa_cfg.sv -----
// ----------------------------------------------------------------------------
// sdsa_cfg: configuration registers
// APB-style register file holding the read start address, the response poll
// limit and the number of wake-up bytes. Writes complete in the access cycle.
// ----------------------------------------------------------------------------
module sdsa_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdsa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sdsa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sdsa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output sdsa_pkg::t_cfg                  o_cfg
);
    import sdsa_pkg::*;

    logic [31:0] r_start_address;
    logic [7:0]  r_poll_limit;
    logic [7:0]  r_wakeup_bytes;
    logic        w_write;
    logic [1:0]  w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[3:2];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_address <= START_ADDRESS_RST;
            r_poll_limit    <= POLL_LIMIT_RST;
            r_wakeup_bytes  <= WAKEUP_BYTES_RST;
        end else if (w_write) begin
            case (w_index)
                REG_START_ADDRESS: r_start_address <= pwdata;
                REG_POLL_LIMIT:    r_poll_limit    <= pwdata[7:0];
                REG_WAKEUP_BYTES:  r_wakeup_bytes  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_index)
            REG_START_ADDRESS: prdata = r_start_address;
            REG_POLL_LIMIT:    prdata = {24'd0, r_poll_limit};
            REG_WAKEUP_BYTES:  prdata = {24'd0, r_wakeup_bytes};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.start_address = r_start_address;
    assign o_cfg.poll_limit    = r_poll_limit;
    assign o_cfg.wakeup_bytes  = r_wakeup_bytes;

endmodule

// ----- rtl/sdsa_core.sv -----
// ----------------------------------------------------------------------------
// sdsa_core: card initialisation and block streaming sequencer
// Holds the sequencer state and works out, for one completed byte exchange,
// the next state and the byte, select level, sample and status that follow.
// ----------------------------------------------------------------------------
module sdsa_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_op,
    input  logic [7:0]        i_rx_byte,
    input  sdsa_pkg::t_cfg    i_cfg,
    output sdsa_pkg::t_result o_result
);
    import sdsa_pkg::*;

    // Each command has a send, a poll and a trailing clock phase.
    typedef enum logic [4:0] {
        PH_WAKE     = 5'd0,
        PH_C0_SEND  = 5'd1,
        PH_C0_POLL  = 5'd2,
        PH_C0_CLK   = 5'd3,
        PH_C8_SEND  = 5'd4,
        PH_C8_POLL  = 5'd5,
        PH_C8_CLK   = 5'd6,
        PH_C55_SEND = 5'd7,
        PH_C55_POLL = 5'd8,
        PH_C55_CLK  = 5'd9,
        PH_C41_SEND = 5'd10,
        PH_C41_POLL = 5'd11,
        PH_C41_CLK  = 5'd12,
        PH_C18_SEND = 5'd13,
        PH_C18_POLL = 5'd14,
        PH_C18_CLK  = 5'd15,
        PH_TAIL     = 5'd16,
        PH_TOKEN    = 5'd17,
        PH_DATA     = 5'd18,
        PH_CRC      = 5'd19,
        PH_HALT     = 5'd20
    } t_phase;

    localparam logic [7:0] CMD_FLAG      = 8'h40;
    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] DATA_TOKEN    = 8'hFE;
    localparam logic [7:0] R1_IDLE       = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;
    localparam logic [7:0] CRC_CMD0      = 8'h95;
    localparam logic [7:0] CRC_CMD8      = 8'h87;
    localparam logic [31:0] ARG_CMD8     = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41   = 32'h4000_0000;
    localparam logic [7:0] CODE_CMD0     = 8'd0;
    localparam logic [7:0] CODE_CMD8     = 8'd8;
    localparam logic [7:0] CODE_CMD55    = 8'd55;
    localparam logic [7:0] CODE_ACMD41   = 8'd41;
    localparam logic [7:0] CODE_CMD18    = 8'd18;
    localparam logic [7:0] SEND_BYTES    = 8'd6;
    localparam logic [7:0] CLK_BYTES     = 8'd2;
    localparam logic [7:0] CRC_BYTES     = 8'd2;
    localparam logic [7:0] TAIL_BYTES    = 8'(CMD8_TAIL_BYTES);
    localparam logic [7:0] PAIRS_WRAP    = 8'(PAIRS_PER_BLOCK);

    t_phase     r_phase, n_phase;
    logic [7:0] r_byte_count, n_byte_count;
    logic [7:0] r_poll_count, n_poll_count;
    logic [7:0] r_pair_count, n_pair_count;
    logic       r_pair_half, n_pair_half;
    logic [7:0] r_last_resp, n_last_resp;

    logic [7:0]  w_bc_inc;
    logic [7:0]  w_pc_inc;
    logic [7:0]  w_pair_inc;
    logic [7:0]  w_code;
    logic [31:0] w_arg;
    logic [7:0]  w_crc;
    logic        w_sample_valid;
    logic [7:0]  w_sample;

    assign w_bc_inc   = r_byte_count + 8'd1;
    assign w_pc_inc   = r_poll_count + 8'd1;
    assign w_pair_inc = r_pair_count + 8'd1;

    // Next state for one completed exchange.
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_poll_count = r_poll_count;
        n_pair_count = r_pair_count;
        n_pair_half  = r_pair_half;
        n_last_resp  = r_last_resp;
        w_sample_valid = 1'b0;
        w_sample       = 8'd0;

        if (!i_op) begin
            n_phase      = PH_WAKE;
            n_byte_count = 8'd0;
            n_poll_count = 8'd0;
            n_pair_count = 8'd0;
            n_pair_half  = 1'b0;
            n_last_resp  = BYTE_IDLE;
        end else begin
            case (r_phase)
                PH_WAKE: begin
                    if (w_bc_inc == i_cfg.wakeup_bytes) begin
                        n_phase      = PH_C0_SEND;
                        n_byte_count = 8'd0;
                        n_poll_count = 8'd0;
                    end else begin
                        n_byte_count = w_bc_inc;
                    end
                end
                PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_C41_SEND, PH_C18_SEND: begin
                    n_byte_count = w_bc_inc;
                    if (w_bc_inc >= SEND_BYTES) begin
                        n_phase      = t_phase'(r_phase + 5'd1);
                        n_poll_count = 8'd0;
                    end
                end
                PH_C0_POLL, PH_C8_POLL, PH_C55_POLL, PH_C41_POLL, PH_C18_POLL: begin
                    n_last_resp  = i_rx_byte;
                    n_poll_count = w_pc_inc;
                    if (i_rx_byte != BYTE_IDLE || w_pc_inc == i_cfg.poll_limit) begin
                        n_phase      = t_phase'(r_phase + 5'd1);
                        n_byte_count = 8'd0;
                    end
                end
                PH_C0_CLK, PH_C8_CLK, PH_C55_CLK, PH_C41_CLK, PH_C18_CLK: begin
                    n_byte_count = w_bc_inc;
                    if (w_bc_inc >= CLK_BYTES) begin
                        // The command is done: pick what follows it.
                        n_byte_count = 8'd0;
                        n_poll_count = 8'd0;
                        case (r_phase)
                            PH_C0_CLK: begin
                                if (r_last_resp == R1_IDLE) begin
                                    n_phase = PH_C8_SEND;
                                end else begin
                                    n_phase      = PH_HALT;
                                    n_byte_count = w_bc_inc;
                                    n_poll_count = r_poll_count;
                                end
                            end
                            PH_C8_CLK: begin
                                if (CMD8_TAIL_BYTES > 0) begin
                                    n_phase      = PH_TAIL;
                                    n_poll_count = r_poll_count;
                                end else begin
                                    n_phase = PH_C55_SEND;
                                end
                            end
                            PH_C55_CLK: n_phase = PH_C41_SEND;
                            PH_C41_CLK: begin
                                n_phase = (r_last_resp == R1_READY) ? PH_C18_SEND
                                                                    : PH_C55_SEND;
                            end
                            default: begin
                                if (r_last_resp == R1_READY) begin
                                    n_phase      = PH_TOKEN;
                                    n_byte_count = w_bc_inc;
                                    n_poll_count = r_poll_count;
                                end else begin
                                    n_phase = PH_C18_SEND;
                                end
                            end
                        endcase
                    end
                end
                PH_TAIL: begin
                    if (w_bc_inc >= TAIL_BYTES) begin
                        n_phase      = PH_C55_SEND;
                        n_byte_count = 8'd0;
                        n_poll_count = 8'd0;
                    end else begin
                        n_byte_count = w_bc_inc;
                    end
                end
                PH_TOKEN: begin
                    if (i_rx_byte == DATA_TOKEN) begin
                        n_phase      = PH_DATA;
                        n_pair_count = 8'd0;
                        n_pair_half  = 1'b0;
                    end
                end
                PH_DATA: begin
                    if (!r_pair_half) begin
                        n_pair_half = 1'b1;
                    end else begin
                        // Second byte of a pair is the audio sample.
                        w_sample_valid = 1'b1;
                        w_sample       = i_rx_byte;
                        n_pair_half    = 1'b0;
                        n_pair_count   = w_pair_inc;
                        if (w_pair_inc == PAIRS_WRAP) begin
                            n_phase      = PH_CRC;
                            n_byte_count = 8'd0;
                        end
                    end
                end
                PH_CRC: begin
                    n_byte_count = w_bc_inc;
                    if (w_bc_inc >= CRC_BYTES) begin
                        n_phase = PH_TOKEN;
                    end
                end
                default: n_phase = PH_HALT;
            endcase
        end
    end

    // Command frame contents for the command being sent.
    always_comb begin
        case (n_phase)
            PH_C0_SEND: begin
                w_code = CODE_CMD0;   w_arg = 32'd0;                w_crc = CRC_CMD0;
            end
            PH_C8_SEND: begin
                w_code = CODE_CMD8;   w_arg = ARG_CMD8;             w_crc = CRC_CMD8;
            end
            PH_C55_SEND: begin
                w_code = CODE_CMD55;  w_arg = 32'd0;                w_crc = BYTE_IDLE;
            end
            PH_C41_SEND: begin
                w_code = CODE_ACMD41; w_arg = ARG_ACMD41;           w_crc = BYTE_IDLE;
            end
            PH_C18_SEND: begin
                w_code = CODE_CMD18;  w_arg = i_cfg.start_address;  w_crc = BYTE_IDLE;
            end
            default: begin
                w_code = CODE_CMD0;   w_arg = 32'd0;                w_crc = BYTE_IDLE;
            end
        endcase
    end

    // Byte, select, sample and status for the next exchange.
    always_comb begin
        o_result.tx_byte       = BYTE_IDLE;
        o_result.card_select_n = 1'b0;
        o_result.sample_valid  = w_sample_valid;
        o_result.sample        = w_sample;
        o_result.status        = ST_INIT;
        case (n_phase)
            PH_WAKE: o_result.card_select_n = 1'b1;
            PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_C41_SEND, PH_C18_SEND: begin
                // Command byte, argument most significant byte first, then CRC.
                case (n_byte_count)
                    8'd0:    o_result.tx_byte = w_code | CMD_FLAG;
                    8'd1:    o_result.tx_byte = w_arg[31:24];
                    8'd2:    o_result.tx_byte = w_arg[23:16];
                    8'd3:    o_result.tx_byte = w_arg[15:8];
                    8'd4:    o_result.tx_byte = w_arg[7:0];
                    default: o_result.tx_byte = w_crc;
                endcase
            end
            PH_TOKEN, PH_DATA, PH_CRC: o_result.status = ST_STREAM;
            PH_HALT: begin
                o_result.card_select_n = 1'b1;
                o_result.status        = ST_HALTED;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAKE;
            r_byte_count <= 8'd0;
            r_poll_count <= 8'd0;
            r_pair_count <= 8'd0;
            r_pair_half  <= 1'b0;
            r_last_resp  <= BYTE_IDLE;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_poll_count <= n_poll_count;
            r_pair_count <= n_pair_count;
            r_pair_half  <= n_pair_half;
            r_last_resp  <= n_last_resp;
        end
    end

endmodule
